// ===== rtl/hash_table_linear_probe_macros.svh =====
// Assertion macros for the linear-probe hash table.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef HASH_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTLP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, checked outside reset.
`define HTLP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

// ===== rtl/htlp_pkg.sv =====
// Shared types and defaults for the linear-probe hash table.
// No dependencies.
`timescale 1ns / 1ps

package htlp_pkg;

  localparam int SLOTS_DEF      = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RESP
  } state_e;

endpackage

// ===== rtl/hash_table_linear_probe.sv =====
// With SLOTS a power of two the home slot is read as the beat is accepted; otherwise the
// key is first reduced in S_MOD, ceil(KEY_BITS / 4) digit steps. S_PROBE judges 1 to SLOTS
// slots; the result waits in S_RESP, where a reserved cmd goes straight. A new beat is
// taken only once S_RESP has loaded the output register, which waits while out_ready_i is
// low; the single read port of the slot memory walks one slot a cycle. After reset the block
// sweeps every slot to empty with in_ready_o low; the output register resets empty.
`timescale 1ns / 1ps

module hash_table_linear_probe #(
  parameter int SLOTS      = htlp_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = htlp_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        lookup_key_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = 2 + KEY_BITS + VALUE_BITS;
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Home-slot reduction: four key bits a cycle, each set bit adds its constant
  // residue 2^b mod SLOTS, and the running sum is folded back below SLOTS.
  localparam int DIG_BITS = 4;
  localparam int N_DIG    = (KEY_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int DIG_W    = (N_DIG > 1) ? $clog2(N_DIG) : 1;
  localparam int KEY_EXT  = N_DIG * DIG_BITS;
  localparam int SUM_W    = IDX_W + 3;
  localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(N_DIG - 1);

  function automatic logic [KEY_EXT*IDX_W-1:0] res_table();
    logic [KEY_EXT*IDX_W-1:0] tab;
    int r;
    tab = '0;
    r   = 1 % SLOTS;
    for (int b = 0; b < KEY_EXT; b++) begin
      tab[b*IDX_W +: IDX_W] = IDX_W'(r);
      r = (2 * r) % SLOTS;
    end
    return tab;
  endfunction

  localparam logic [KEY_EXT*IDX_W-1:0] RES_TAB = res_table();

  // ------------------------------------------------------------------
  // Slot memory: one word per slot holds {mark, key, value}.
  // One write port, one registered read port.
  // ------------------------------------------------------------------
  logic [ENT_W-1:0] slot_mem [SLOTS];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [ENT_W-1:0] mem_wd;
  logic [ENT_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= slot_mem[mem_ra];
    end
  end

  logic [1:0]            rd_mark;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  assign rd_mark = rd_q[ENT_W-1 -: 2];
  assign rd_key  = rd_q[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
  assign rd_val  = rd_q[VALUE_BITS-1:0];

  // ------------------------------------------------------------------
  // Input shaping: keys are zero-padded or cut to KEY_BITS, values are
  // sign-extended or cut to VALUE_BITS.
  // ------------------------------------------------------------------
  logic [KEY_BITS+31:0]   key_wide;
  logic [VALUE_BITS+31:0] val_wide;
  logic [KEY_BITS-1:0]    key_in;
  logic [VALUE_BITS-1:0]  val_in;
  logic [KEY_BITS+IDX_W-1:0] key_pad;
  logic [IDX_W-1:0]       home_pow2;
  logic [VALUE_BITS+31:0] rd_val_wide;

  assign key_wide    = {{KEY_BITS{1'b0}}, lookup_key_i};
  assign val_wide    = {{VALUE_BITS{item_value_i[31]}}, item_value_i};
  assign key_in      = key_wide[KEY_BITS-1:0];
  assign val_in      = val_wide[VALUE_BITS-1:0];
  assign key_pad     = {{IDX_W{1'b0}}, key_in};
  assign home_pow2   = key_pad[IDX_W-1:0];
  assign rd_val_wide = {32'b0, rd_val};

  // ------------------------------------------------------------------
  // Sequencer registers
  // ------------------------------------------------------------------
  htlp_pkg::state_e  state_q, state_d;
  htlp_pkg::cmd_e    cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IDX_W-1:0]  idx_q, idx_d;      // probe slot, also the clear pointer
  logic [IDX_W-1:0]  cnt_q, cnt_d;      // slots probed so far
  logic [IDX_W-1:0]  tomb_q, tomb_d;
  logic              tomb_v_q, tomb_v_d;
  logic [IDX_W-1:0]  rem_q, rem_d;      // running key residue
  logic [DIG_W-1:0]  dig_q, dig_d;      // key digit folded into the residue
  logic [31:0]       res_rv_q, res_rv_d;
  htlp_pkg::status_e res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_rv_q, out_rv_d;
  htlp_pkg::status_e out_st_q, out_st_d;

  // Shared step logic: next slot with wrap, one residue-fold step.
  logic [IDX_W-1:0]          idx_nxt;
  logic [KEY_BITS+DIG_BITS-1:0] key_fold;
  logic [KEY_EXT-1:0]        key_ext;
  logic [DIG_BITS-1:0]       dig_bits;
  logic [SUM_W-1:0]          res_term [DIG_BITS];
  logic [SUM_W-1:0]          res_sum, res_red;
  logic [IDX_W-1:0]          rem_nxt;
  assign idx_nxt  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign key_fold = {{DIG_BITS{1'b0}}, key_q};
  assign key_ext  = key_fold[KEY_EXT-1:0];
  assign dig_bits = key_ext[dig_q*DIG_BITS +: DIG_BITS];

  always_comb begin
    for (int j = 0; j < DIG_BITS; j++) begin
      res_term[j] = dig_bits[j] ?
                    {{(SUM_W-IDX_W){1'b0}}, RES_TAB[(dig_q*DIG_BITS + j)*IDX_W +: IDX_W]} :
                    '0;
    end
    // residue below SLOTS plus four residues stays below 5 * SLOTS
    res_sum = {{(SUM_W-IDX_W){1'b0}}, rem_q} + (res_term[0] + res_term[1]) +
              (res_term[2] + res_term[3]);
    res_red = res_sum;
    for (int k = 1; k <= DIG_BITS; k++) begin
      if (res_sum >= SUM_W'(k * SLOTS)) begin
        res_red = res_sum - SUM_W'(k * SLOTS);
      end
    end
  end
  assign rem_nxt = res_red[IDX_W-1:0];

  // Probe decision on the slot just read.
  logic             hit, is_empty, is_last, tomb_any;
  logic [IDX_W-1:0] tomb_at;
  assign hit      = (rd_mark == htlp_pkg::MARK_USED) && (rd_key == key_q);
  assign is_empty = (rd_mark == htlp_pkg::MARK_EMPTY);
  assign is_last  = (cnt_q == LAST_IDX);
  assign tomb_any = tomb_v_q || (rd_mark == htlp_pkg::MARK_DELETED);
  assign tomb_at  = tomb_v_q ? tomb_q : idx_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    tomb_d      = tomb_q;
    tomb_v_d    = tomb_v_q;
    rem_d       = rem_q;
    dig_d       = dig_q;
    res_rv_d    = res_rv_q;
    res_st_d    = res_st_q;
    // drop the output beat once taken
    out_valid_d = out_valid_q && !out_ready_i;
    out_rv_d    = out_rv_q;
    out_st_d    = out_st_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = {htlp_pkg::MARK_USED, key_q, val_q};
    mem_re      = 1'b0;
    mem_ra      = idx_nxt;

    unique case (state_q)
      // Sweep every slot to empty, one per cycle.
      htlp_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {htlp_pkg::MARK_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
        idx_d  = idx_nxt;
        if (idx_q == LAST_IDX) begin
          state_d = htlp_pkg::S_IDLE;
        end
      end

      // Take a beat; start the home-slot read or the residue walk, or answer a reserved cmd.
      htlp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d    = key_in;
          val_d    = val_in;
          cnt_d    = '0;
          tomb_v_d = 1'b0;
          unique case (cmd_i)
            htlp_pkg::CMD_INSERT, htlp_pkg::CMD_LOOKUP, htlp_pkg::CMD_DELETE: begin
              cmd_d = htlp_pkg::cmd_e'(cmd_i);
              if (SLOTS_POW2) begin
                mem_re  = 1'b1;
                mem_ra  = home_pow2;
                idx_d   = home_pow2;
                state_d = htlp_pkg::S_PROBE;
              end else begin
                rem_d   = '0;
                dig_d   = '0;
                state_d = htlp_pkg::S_MOD;
              end
            end
            default: begin
              // reserved command: answer done, leave the table alone
              res_rv_d = '0;
              res_st_d = htlp_pkg::ST_DONE;
              state_d  = htlp_pkg::S_RESP;
            end
          endcase
        end
      end

      // Home slot = key mod SLOTS, one four-bit key digit per cycle.
      htlp_pkg::S_MOD: begin
        rem_d = rem_nxt;
        dig_d = dig_q + 1'b1;
        if (dig_q == LAST_DIG) begin
          mem_re  = 1'b1;
          mem_ra  = rem_nxt;
          idx_d   = rem_nxt;
          state_d = htlp_pkg::S_PROBE;
        end
      end

      // One slot per cycle: judge the slot in rd_q while the next one is read.
      htlp_pkg::S_PROBE: begin
        mem_re = 1'b1;
        mem_ra = idx_nxt;
        idx_d  = idx_nxt;
        cnt_d  = cnt_q + 1'b1;
        if (is_empty || hit || is_last) begin
          state_d  = htlp_pkg::S_RESP;
          res_rv_d = '0;
          res_st_d = htlp_pkg::ST_DONE;
          case (cmd_q)
            htlp_pkg::CMD_INSERT: begin
              if (hit) begin
                mem_we = 1'b1;
                mem_wa = idx_q;
              end else if (tomb_any) begin
                mem_we = 1'b1;
                mem_wa = tomb_at;
              end else if (is_empty) begin
                mem_we = 1'b1;
                mem_wa = idx_q;
              end else begin
                res_st_d = htlp_pkg::ST_FULL;
              end
            end
            htlp_pkg::CMD_LOOKUP: begin
              if (hit) begin
                res_rv_d = rd_val_wide[31:0];
              end else begin
                res_rv_d = '1;
                res_st_d = htlp_pkg::ST_MISS;
              end
            end
            default: begin
              // delete: tombstone the first match only
              if (hit) begin
                mem_we = 1'b1;
                mem_wa = idx_q;
                mem_wd = {htlp_pkg::MARK_DELETED, rd_key, rd_val};
              end else begin
                res_st_d = htlp_pkg::ST_MISS;
              end
            end
          endcase
        end else if ((rd_mark == htlp_pkg::MARK_DELETED) && !tomb_v_q) begin
          // remember the first tombstone for a later insert
          tomb_v_d = 1'b1;
          tomb_d   = idx_q;
        end
      end

      // Hold the result until the output register is free.
      htlp_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rv_d    = res_rv_q;
          out_st_d    = res_st_q;
          state_d     = htlp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = htlp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htlp_pkg::S_CLEAR;
      cmd_q       <= htlp_pkg::CMD_INSERT;
      idx_q       <= '0;
      cnt_q       <= '0;
      tomb_v_q    <= 1'b0;
      rem_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      tomb_v_q    <= tomb_v_d;
      rem_q       <= rem_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    val_q    <= val_d;
    tomb_q   <= tomb_d;
    res_rv_q <= res_rv_d;
    res_st_q <= res_st_d;
    out_rv_q <= out_rv_d;
    out_st_q <= out_st_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = $signed(out_rv_q);
  assign status_o     = out_st_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`include "hash_table_linear_probe_macros.svh"

  logic in_beat, resp_go, resp_full, write_ok;
  assign in_beat   = in_valid_i && in_ready_o;
  assign resp_go   = (state_q == htlp_pkg::S_RESP) && (!out_valid_q || out_ready_i);
  assign resp_full = (state_q == htlp_pkg::S_RESP) && (res_st_q == htlp_pkg::ST_FULL);
  assign write_ok  = (state_q == htlp_pkg::S_CLEAR) || (state_q == htlp_pkg::S_PROBE);

  `HTLP_ASSERT_IMPL(a_write_state, mem_we, write_ok)
  `HTLP_ASSERT_IMPL(a_full_is_insert, resp_full, cmd_q == htlp_pkg::CMD_INSERT)
  `HTLP_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready_o)
  `HTLP_ASSERT_NEXT(a_resp_loads_out, resp_go, out_valid_q && out_st_q == $past(res_st_q))

endmodule
